>>> rtl/fcw_pkg.sv
// ----------------------------------------------------------------------------
// fcw_pkg
// Shared types and constants for the cluster chain walker: field widths,
// command codes, end mark and floppy geometry constants.
// ----------------------------------------------------------------------------
`default_nettype none

package fcw_pkg;

    // field widths
    localparam int CLUSTER_W = 12;
    localparam int COUNT_W   = 7;
    localparam int CYL_W     = 7;
    localparam int SECTOR_W  = 5;
    localparam int BLOCK_W   = 13;
    localparam int TRACK_W   = 8;

    // parameter defaults
    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int MAX_CHAIN_DEF   = 64;

    // command codes carried in tuser
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_WALK = 1'b1;

    // table values
    localparam logic [CLUSTER_W-1:0] END_MARK = 12'hFF0;
    localparam logic [CLUSTER_W-1:0] END_READ = 12'hFFF;

    // geometry: data area starts at byte 0x3e00, 512-byte sectors
    localparam int FIRST_BYTE        = 'h3e00;
    localparam int SECTOR_BYTES      = 'h200;
    localparam int FIRST_BLOCK       = FIRST_BYTE / SECTOR_BYTES;
    localparam int SECTORS_PER_TRACK = 18;

    // reciprocal of the track length, rounded up, with 16 fraction bits
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP       = ((1 << RECIP_SHIFT) + SECTORS_PER_TRACK - 1)
                                 / SECTORS_PER_TRACK;
    localparam int RECIP_W     = 12;

    // mapped floppy address of one cluster
    typedef struct packed {
        logic [CYL_W-1:0]    cylinder;
        logic                head;
        logic [SECTOR_W-1:0] sector;
    } chs_t;

endpackage

`default_nettype wire

>>> rtl/fcw_table.sv
// ----------------------------------------------------------------------------
// fcw_table
// Next-cluster allocation table: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fcw_table import fcw_pkg::*; #(
    parameter int DEPTH  = TABLE_DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                 aclk,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_W-1:0]    wr_addr,
    input  wire logic [CLUSTER_W-1:0] wr_data,
    input  wire logic                 rd_en,
    input  wire logic [ADDR_W-1:0]    rd_addr,
    output logic      [CLUSTER_W-1:0] rd_data
);

    logic [CLUSTER_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/fcw_chs.sv
// ----------------------------------------------------------------------------
// fcw_chs
// Two-stage cluster to cylinder/head/sector mapper. The track number comes
// from a reciprocal multiply, the sector from the remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module fcw_chs import fcw_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic [CLUSTER_W-1:0] cluster,
    output chs_t                      chs
);

    localparam int PROD_W = BLOCK_W + RECIP_W;

    logic [BLOCK_W-1:0] blk;
    logic [BLOCK_W-1:0] blk_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [TRACK_W-1:0] trk;
    logic [BLOCK_W-1:0] trk_ext;
    logic [BLOCK_W-1:0] rem;

    assign blk = BLOCK_W'(cluster) + BLOCK_W'(FIRST_BLOCK);

    // stage 1: block number and reciprocal product
    always_ff @(posedge aclk) begin
        blk_reg  <= blk;
        prod_reg <= PROD_W'(blk) * PROD_W'(RECIP);
    end

    // stage 2: track, remainder by shift-add of 18
    assign trk     = prod_reg[RECIP_SHIFT +: TRACK_W];
    assign trk_ext = BLOCK_W'(trk);
    assign rem     = blk_reg - (trk_ext << 4) - (trk_ext << 1);

    always_ff @(posedge aclk) begin
        chs.cylinder <= trk[TRACK_W-1:1];
        chs.head     <= trk[0];
        chs.sector   <= rem[SECTOR_W-1:0] + SECTOR_W'(1);
    end

endmodule

`default_nettype wire

>>> rtl/fat12_chain_walk_chs_core.sv
// A load word is taken while the sequencer is idle and gives no result.
// A walk steps each cluster through a table read, read data and output load
// state; the output load waits while a result is held and m_tready is low.
// s_tready is low from an accepted walk until its last result word is loaded.
// Reset: aresetn synchronous active low clears the sequencer and output valid;
// the table holds no reset value and must be written before it is walked.
`default_nettype none

// ----------------------------------------------------------------------------
// fat12_chain_walk_chs_core
// Walks a FAT12 cluster chain held in an on-chip table and emits each
// cluster with its floppy cylinder, head and sector.
// ----------------------------------------------------------------------------
module fat12_chain_walk_chs_core import fcw_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int MAX_CHAIN   = MAX_CHAIN_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,  // entry_index, entry_value, start_cluster, pad
    input  wire logic        s_tuser,  // cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,  // cluster_number, cylinder, head, sector, pad
    output logic             m_tlast,
    output logic             m_tuser   // truncated
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam logic [CLUSTER_W:0]   DEPTH_LIM = (CLUSTER_W + 1)'(TABLE_DEPTH);
    localparam logic [COUNT_W-1:0]   CHAIN_LIM = COUNT_W'(MAX_CHAIN);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RD   = 4'b0010,
        ST_WT   = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [CLUSTER_W-1:0] cur_reg, cur_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [CLUSTER_W-1:0] next_reg;
    logic                 oor_reg;
    logic                 last_reg;
    logic                 trunc_reg;
    logic                 m_tvalid_reg;
    logic [31:0]          m_tdata_reg;
    logic                 m_tlast_reg;
    logic                 m_tuser_reg;

    logic [CLUSTER_W-1:0] s_index;
    logic [CLUSTER_W-1:0] s_value;
    logic [CLUSTER_W-1:0] s_start;
    logic                 s_accept;
    logic                 wr_en;
    logic [CLUSTER_W-1:0] rd_data;
    logic [CLUSTER_W-1:0] next_val;
    logic [COUNT_W-1:0]   count_inc;
    logic                 is_end;
    logic                 is_cut;
    logic                 slot_free;
    logic                 out_load;
    chs_t                 chs;

    // input word unpacking
    assign s_index  = s_tdata[11:0];
    assign s_value  = s_tdata[23:12];
    assign s_start  = s_tdata[35:24];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // table load, loads beyond the table are dropped
    assign wr_en = s_accept && (s_tuser == CMD_LOAD) && ({1'b0, s_index} < DEPTH_LIM);

    fcw_table #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (s_index[ADDR_W-1:0]),
        .wr_data (s_value),
        .rd_en   (state_reg == ST_RD),
        .rd_addr (cur_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    fcw_chs u_chs (
        .aclk    (aclk),
        .cluster (cur_reg),
        .chs     (chs)
    );

    // reads past the table answer as an end mark
    assign next_val  = oor_reg ? END_READ : rd_data;
    assign count_inc = count_reg + COUNT_W'(1);
    assign is_end    = (next_val >= END_MARK);
    assign is_cut    = (count_inc >= CHAIN_LIM);
    assign slot_free = !m_tvalid_reg || m_tready;
    assign out_load  = (state_reg == ST_OUT) && slot_free;

    // sequencer
    always_comb begin
        state_next = state_reg;
        cur_next   = cur_reg;
        count_next = count_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept && (s_tuser == CMD_WALK)) begin
                    cur_next   = s_start;
                    count_next = '0;
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                state_next = ST_WT;
            end
            ST_WT: begin
                count_next = count_inc;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (slot_free) begin
                    if (last_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        cur_next   = next_reg;
                        state_next = ST_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cur_reg   <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            count_reg <= count_next;
        end
    end

    // read bookkeeping: range flag with the read, end and cut after it
    always_ff @(posedge aclk) begin
        if (state_reg == ST_RD) begin
            oor_reg <= ({1'b0, cur_reg} >= DEPTH_LIM);
        end
        if (state_reg == ST_WT) begin
            next_reg  <= next_val;
            last_reg  <= is_end || is_cut;
            trunc_reg <= !is_end && is_cut;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {7'b0, chs.sector, chs.head, chs.cylinder, cur_reg};
            m_tlast_reg <= last_reg;
            m_tuser_reg <= trunc_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    // chain count never passes the bound
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CHAIN_LIM)
        else $error("chain count beyond bound");

    // a cut chain is always flagged on its final word
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("truncated word without last");

    // an accepted walk starts a table read next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && (s_tuser == CMD_WALK) |=> state_reg == ST_RD)
        else $error("walk did not start a read");

    // a result waiting on a full output register holds the sequencer
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) && !slot_free |=> state_reg == ST_OUT)
        else $error("sequencer left output state while stalled");
`endif

endmodule

`default_nettype wire

>>> test/fat12_chain_walk_chs_core_tb.sv
`timescale 1ns / 100ps

// ----------------------------------------------------------------------------
// fat12_chain_walk_chs_core_tb
// Self-checking bench for the cluster chain walker. Table words and walk
// words go in on the slave stream; every cluster word that comes out is
// checked against a bench-side copy of the allocation table and a chain
// follower that maps each cluster to cylinder, head and sector.
// ----------------------------------------------------------------------------
module fat12_chain_walk_chs_core_tb;
    import fcw_pkg::*;

    localparam int CHAIN_LIMIT    = MAX_CHAIN_DEF;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int IDLE_PCT       = 29;
    localparam int PRINT_CAP      = 40;

    // one expected result word
    typedef struct packed {
        logic [CLUSTER_W-1:0] cluster;
        logic [CYL_W-1:0]     cylinder;
        logic                 head;
        logic [SECTOR_W-1:0]  sector;
        logic                 last;
        logic                 truncated;
    } chain_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // entry_index, entry_value, start_cluster, pad
    logic        s_tuser;   // cmd
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // cluster_number, cylinder, head, sector, pad
    logic        m_tlast;
    logic        m_tuser;   // truncated

    // bench copy of the allocation table
    logic [CLUSTER_W-1:0] fat_table   [0:TABLE_DEPTH_DEF-1];
    bit                   fat_written [0:TABLE_DEPTH_DEF-1];
    logic [CLUSTER_W-1:0] written_list[$];

    chain_result_t        chain_results_due[$];
    chain_result_t        due_word;
    logic [CLUSTER_W-1:0] chain_nodes[$];

    bit steady;
    int mismatch_count;
    int words_sent;
    int walks_sent;
    int results_seen;
    int truncated_seen;
    int idle_cycles;

    fat12_chain_walk_chs_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // clock
    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // mismatch report
    task automatic note_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP) begin
            $display("[%0t] mismatch on %s: got %0d, want %0d (result word %0d)",
                     $time, what, got, want, results_seen);
        end
    endtask

    // follow the chain from one start cluster and queue its result words
    task automatic predict_chain_walk(input logic [CLUSTER_W-1:0] first);
        logic [CLUSTER_W-1:0] cur;
        logic [CLUSTER_W-1:0] nxt;
        chain_result_t        r;
        int                   blk;
        int                   n;
        cur = first;
        for (n = 1; n <= CHAIN_LIMIT; n++) begin
            nxt         = fat_table[cur];
            blk         = FIRST_BLOCK + int'(cur);
            r.cluster   = cur;
            r.cylinder  = CYL_W'(blk / (2 * SECTORS_PER_TRACK));
            r.head      = 1'((blk / SECTORS_PER_TRACK) % 2);
            r.sector    = SECTOR_W'(blk % SECTORS_PER_TRACK + 1);
            r.last      = (nxt >= END_MARK) || (n == CHAIN_LIMIT);
            r.truncated = (nxt < END_MARK) && (n == CHAIN_LIMIT);
            chain_results_due.push_back(r);
            if (r.last) break;
            cur = nxt;
        end
    endtask

    // a walk only touches written entries, up to the chain bound
    function automatic bit walk_is_safe(input logic [CLUSTER_W-1:0] first);
        logic [CLUSTER_W-1:0] cur;
        int                   n;
        cur = first;
        for (n = 1; n <= CHAIN_LIMIT; n++) begin
            if (!fat_written[cur]) return 1'b0;
            if (fat_table[cur] >= END_MARK) return 1'b1;
            cur = fat_table[cur];
        end
        return 1'b1;
    endfunction

    // send one word; called and returns at a falling edge
    task automatic send_word(input logic cmd, input logic [CLUSTER_W-1:0] idx,
                             input logic [CLUSTER_W-1:0] val,
                             input logic [CLUSTER_W-1:0] first);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = {4'b0000, first, val, idx};
        do @(posedge aclk); while (!s_tready);
        words_sent++;
        if (cmd == CMD_LOAD) begin
            if (!fat_written[idx]) written_list.push_back(idx);
            fat_table[idx]   = val;
            fat_written[idx] = 1'b1;
        end else begin
            walks_sent++;
            predict_chain_walk(first);
        end
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic load_entry(input logic [CLUSTER_W-1:0] idx,
                              input logic [CLUSTER_W-1:0] val);
        send_word(CMD_LOAD, idx, val, CLUSTER_W'($urandom));
    endtask

    task automatic walk_from(input logic [CLUSTER_W-1:0] first);
        send_word(CMD_WALK, CLUSTER_W'($urandom), CLUSTER_W'($urandom), first);
    endtask

    // hold the sender until every expected word is back
    task automatic wait_drained();
        while (chain_results_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    // pick distinct random clusters for a chain
    task automatic pick_chain_nodes(input int count);
        logic [CLUSTER_W-1:0] c;
        bit                   dup;
        chain_nodes.delete();
        while (chain_nodes.size() < count) begin
            c   = CLUSTER_W'($urandom);
            dup = 1'b0;
            foreach (chain_nodes[i]) if (chain_nodes[i] == c) dup = 1'b1;
            if (!dup) chain_nodes.push_back(c);
        end
    endtask

    // single-cluster walks at the ends of the cluster range and end-mark range, and a two-cluster walk
    task automatic test_single_cluster_walks();
        load_entry(12'hFFF, 12'hFFF);
        walk_from(12'hFFF);
        load_entry(12'h000, END_MARK);
        walk_from(12'h000);
        // link just below the end mark, then an end mark in the middle of the range
        load_entry(12'h001, END_MARK - 1);
        load_entry(END_MARK - 1, 12'hFF7);
        walk_from(12'h001);
    endtask

    // loops run to the chain bound and come out truncated
    task automatic test_cyclic_chains();
        load_entry(12'h002, 12'h003);
        load_entry(12'h003, 12'h002);
        walk_from(12'h002);
        load_entry(12'h005, 12'h005);
        walk_from(12'h005);
    endtask

    // link to cluster zero, rewritten entries, alternating bit patterns
    task automatic test_link_values();
        load_entry(12'h006, 12'h000);
        walk_from(12'h006);
        load_entry(12'h000, 12'hFFF);
        load_entry(12'hFFF, 12'h000);
        walk_from(12'hFFF);
        load_entry(12'hAAA, 12'h555);
        load_entry(12'h555, 12'hFFE);
        walk_from(12'hAAA);
    endtask

    // chains of 63, 64 and 65 clusters around the bound
    task automatic test_chain_bound();
        pick_chain_nodes(CHAIN_LIMIT + 1);
        for (int i = 0; i < CHAIN_LIMIT; i++) load_entry(chain_nodes[i], chain_nodes[i + 1]);
        load_entry(chain_nodes[CHAIN_LIMIT], CLUSTER_W'($urandom_range(END_MARK, 12'hFFF)));
        walk_from(chain_nodes[1]);
        walk_from(chain_nodes[0]);
        walk_from(chain_nodes[2]);
    endtask

    // mix of short chains, walks of old entries and stray table writes
    task automatic test_random_traffic(input int word_count);
        int                   stop_at;
        int                   pick;
        int                   len;
        logic [CLUSTER_W-1:0] c;
        stop_at = words_sent + word_count;
        while (words_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                load_entry(CLUSTER_W'($urandom), CLUSTER_W'($urandom));
            end else if (pick < 75) begin
                len = $urandom_range(1, 6);
                pick_chain_nodes(len);
                for (int i = 0; i < len - 1; i++) load_entry(chain_nodes[i], chain_nodes[i + 1]);
                if ($urandom_range(4) == 0)
                    load_entry(chain_nodes[len - 1], chain_nodes[0]);
                else
                    load_entry(chain_nodes[len - 1],
                               CLUSTER_W'($urandom_range(END_MARK, 12'hFFF)));
                walk_from(chain_nodes[0]);
            end else if (written_list.size() != 0) begin
                for (int t = 0; t < 8; t++) begin
                    c = written_list[$urandom_range(written_list.size() - 1)];
                    if (walk_is_safe(c)) begin
                        walk_from(c);
                        break;
                    end
                end
            end
        end
    endtask

    // back-to-back words with no idling on either side
    task automatic test_steady_stream();
        steady = 1'b1;
        test_random_traffic(15);
        wait_drained();
        steady = 1'b0;
    endtask

    // receiver stalls
    always @(negedge aclk) begin
        if (!aresetn) m_tready = 1'b0;
        else if (steady) m_tready = 1'b1;
        else m_tready = ($urandom_range(99) >= IDLE_PCT);
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (chain_results_due.size() == 0) begin
                note_mismatch("unexpected result word", int'(m_tdata[11:0]), -1);
            end else begin
                due_word = chain_results_due.pop_front();
                if (m_tdata[11:0] !== due_word.cluster)
                    note_mismatch("cluster_number", int'(m_tdata[11:0]),
                                  int'(due_word.cluster));
                if (m_tdata[18:12] !== due_word.cylinder)
                    note_mismatch("cylinder", int'(m_tdata[18:12]),
                                  int'(due_word.cylinder));
                if (m_tdata[19] !== due_word.head)
                    note_mismatch("head", int'(m_tdata[19]), int'(due_word.head));
                if (m_tdata[24:20] !== due_word.sector)
                    note_mismatch("sector", int'(m_tdata[24:20]), int'(due_word.sector));
                if (m_tlast !== due_word.last)
                    note_mismatch("last", int'(m_tlast), int'(due_word.last));
                if (m_tuser !== due_word.truncated)
                    note_mismatch("truncated", int'(m_tuser), int'(due_word.truncated));
                if (due_word.truncated) truncated_seen++;
            end
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", idle_cycles);
                $display("[fat12_chain_walk_chs_core] ERROR");
                $finish;
            end
        end
    end

    // test sequence
    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_LOAD;
        m_tready = 1'b0;
        steady   = 1'b0;
        for (int i = 0; i < TABLE_DEPTH_DEF; i++) begin
            fat_table[i]   = '0;
            fat_written[i] = 1'b0;
        end
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_single_cluster_walks();
        test_cyclic_chains();
        wait_drained();
        test_link_values();
        test_chain_bound();
        wait_drained();
        test_random_traffic(12);
        test_steady_stream();
        test_random_traffic(6);

        wait_drained();
        foreach (chain_results_due[i])
            note_mismatch("missing result word", -1, int'(chain_results_due[i].cluster));
        $display("covered %0d input words (%0d walks) and checked %0d result words,",
                 words_sent, walks_sent, results_seen);
        $display("including %0d chains cut at the length bound", truncated_seen);
        if (mismatch_count == 0) begin
            $display("[fat12_chain_walk_chs_core] OK");
        end else begin
            $display("[fat12_chain_walk_chs_core] ERROR");
        end
        $finish;
    end

endmodule
